// ===== src/pots_pkg.sv =====
// Package for the paddle one-shot timers: shared constants, codes and types.
// Used by the lane, merge, top level and checker modules; depends on nothing.
package pots_pkg;

    localparam int NUM_PADDLES_DEF = 4;
    localparam int TIME_BITS_DEF   = 48;

    localparam int NUM_SOURCES = 4;
    localparam int NOW_W       = 47;
    localparam int VAL_W       = 19;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWAP_AXES     = 3'd0,
        CFG_INVERT_VALUES = 3'd1,
        CFG_SCALE_X       = 3'd2,
        CFG_SCALE_Y       = 3'd3,
        CFG_TRIM_X        = 3'd4,
        CFG_TRIM_Y        = 3'd5,
        CFG_SOURCE_SELECT = 3'd6
    } t_cfg_idx;

    localparam logic OP_TRIGGER = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [15:0] SCALE_RESET = 16'd256;

    // mouse mode conversion
    localparam logic signed [11:0] MOUSE_X_OFS  = 12'sd280;
    localparam logic signed [8:0]  MOUSE_X_GAIN = 9'sd117;
    localparam logic signed [11:0] MOUSE_Y_OFS  = 12'sd192;
    localparam logic signed [8:0]  MOUSE_Y_GAIN = 9'sd180;
    localparam logic signed [VAL_W-1:0] FIXED_VAL = 19'sd32767;

    // position arithmetic
    localparam int SCALE_SHIFT = 16;
    localparam logic signed [20:0] POS_CENTRE = 21'sd128;
    localparam logic signed [20:0] POS_LIMIT  = 21'sd255;
    localparam logic signed [20:0] POS_PINNED = 21'sd280;

    // delay = 11*v + ceil(v/25); ceil(v/25) = floor((v + 24 + 25*2^17)/25) - 2^17
    localparam logic signed [24:0] DELAY_WHOLE = 25'sd11;
    localparam logic signed [22:0] DIV_OFS     = 23'sd3276824;
    localparam logic [23:0]        DIV_RECIP   = 24'd10737419;
    localparam int                 DIV_SHIFT   = 28;
    localparam logic signed [18:0] DIV_BIAS    = 19'sd131072;

    localparam logic [7:0] DATA_RUNNING = 8'h80;
    localparam logic [7:0] DATA_EXPIRED = 8'h00;

    typedef struct packed {
        logic               invert;
        logic [15:0]        scale;
        logic signed [7:0]  trim;
    } t_lane_cfg;

endpackage

// ===== src/pots_lane.sv =====
// One timer lane: scales a paddle position, turns it into a deadline and holds it.
// Depends on pots_pkg.
module pots_lane #(
    parameter int TIME_BITS = pots_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [pots_pkg::VAL_W-1:0]   i_value,
    input  pots_pkg::t_lane_cfg                 i_cfg,
    input  logic [pots_pkg::NOW_W-1:0]          i_now,
    input  logic [pots_pkg::NOW_W-1:0]          i_cmp_time,
    output logic                                o_running,
    output logic                                o_busy
);

    localparam int TW = ((TIME_BITS > pots_pkg::NOW_W) ? TIME_BITS : pots_pkg::NOW_W) + 2;
    localparam int CW = TW - 1;
    localparam int VAL_W_L = pots_pkg::VAL_W;

    logic [2:0]               r_vld;
    logic signed [35:0]       r_prod;
    logic signed [20:0]       r_pos;
    logic [45:0]              r_recip;
    logic signed [24:0]       r_pos11;
    logic [TIME_BITS-1:0]     r_deadline;

    logic signed [VAL_W_L-1:0] w_neg;
    logic signed [19:0]       w_shr;
    logic signed [20:0]       w_sum;
    logic signed [20:0]       w_clamped;
    logic signed [22:0]       w_div_in;
    logic signed [18:0]       w_q;
    logic signed [25:0]       w_delay;
    logic signed [TW-1:0]     w_t;
    logic [TIME_BITS-1:0]     w_sat;

    always_comb begin
        w_neg     = i_cfg.invert ? -i_value : i_value;
        w_shr     = r_prod[35:pots_pkg::SCALE_SHIFT];
        w_sum     = 21'(w_shr) + pots_pkg::POS_CENTRE + 21'(i_cfg.trim);
        w_clamped = (w_sum >= pots_pkg::POS_LIMIT) ? pots_pkg::POS_PINNED : w_sum;
        w_div_in  = 23'(r_pos) + pots_pkg::DIV_OFS;
        w_q       = $signed({1'b0, r_recip[45:pots_pkg::DIV_SHIFT]}) - pots_pkg::DIV_BIAS;
        w_delay   = 26'(r_pos11) + 26'(w_q);
        w_t       = TW'($signed({1'b0, i_now})) + TW'(w_delay);
        if (w_t[TW-1]) begin
            w_sat = '0;
        end else if (|w_t[TW-2:TIME_BITS]) begin
            w_sat = '1;
        end else begin
            w_sat = w_t[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_deadline <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
            if (r_vld[2]) begin
                r_deadline <= w_sat;
            end
        end
    end

    // datapath: gain, then centre and clamp, then reciprocal divide
    always_ff @(posedge i_clk) begin
        r_prod  <= 36'(w_neg) * $signed({20'd0, i_cfg.scale});
        r_pos   <= w_clamped;
        r_recip <= 46'(w_div_in[21:0]) * 46'(pots_pkg::DIV_RECIP);
        r_pos11 <= 25'(r_pos) * pots_pkg::DELAY_WHOLE;
    end

    assign o_running = CW'(i_cmp_time) < CW'(r_deadline);
    assign o_busy    = |r_vld;

endmodule

// ===== src/pots_merge.sv =====
// Picks the addressed lane's timer state and holds the read word for the output.
// Depends on pots_pkg.
module pots_merge #(
    parameter int NUM_PADDLES = pots_pkg::NUM_PADDLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_take,
    input  logic [1:0]             i_index,
    input  logic [NUM_PADDLES-1:0] i_running,
    output logic                   o_valid,
    output logic [7:0]             o_data
);

    localparam int IW = $clog2(NUM_PADDLES);

    logic          r_valid;
    logic [7:0]    r_data;
    logic [1:0]    w_idx;
    logic [IW-1:0] w_sel;

    always_comb begin
        // fold an index beyond the timers back into range
        if ({1'b0, i_index} >= 3'(NUM_PADDLES)) begin
            w_idx = i_index - 2'(NUM_PADDLES);
        end else begin
            w_idx = i_index;
        end
        w_sel = w_idx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_running[w_sel] ? pots_pkg::DATA_RUNNING : pots_pkg::DATA_EXPIRED;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/paddle_one_shot_timers_top.sv =====
// Top level of the paddle one-shot timers: ports, configuration, sampling, lanes.
// Depends on pots_pkg, pots_lane and pots_merge.
//
//  channel   direction  handshake                  word
//  in        in         i_in_valid / o_in_ready    operation, time, index, positions
//  out       out        o_out_valid / i_out_ready  read_data
//  cfg       in         i_cfg_valid / o_cfg_ready  register index and data
//
// A read's word appears in the output register the cycle after it is accepted.
// A trigger is sampled on acceptance, then the lane pipeline (gain multiply, clamp,
// reciprocal divide, deadline add) writes the deadlines; no new item is taken
// until they are written.
// Reset clears configuration to its defaults and all deadlines to zero.
// A word waiting at the output holds back new items until it is taken or taken now.
module paddle_one_shot_timers_top #(
    parameter int NUM_PADDLES = pots_pkg::NUM_PADDLES_DEF,
    parameter int TIME_BITS   = pots_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_operation,
    input  logic [pots_pkg::NOW_W-1:0]         i_cycle_time,
    input  logic [1:0]                         i_paddle_index,
    input  logic signed [16:0]                 i_value_zero,
    input  logic signed [16:0]                 i_value_one,
    input  logic signed [16:0]                 i_value_two,
    input  logic signed [16:0]                 i_value_three,
    input  logic [9:0]                         i_mouse_x,
    input  logic [9:0]                         i_mouse_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_read_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pots_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pots_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int VW = pots_pkg::VAL_W;

    logic               r_swap;
    logic               r_invert;
    logic [15:0]        r_scale_x;
    logic [15:0]        r_scale_y;
    logic signed [7:0]  r_trim_x;
    logic signed [7:0]  r_trim_y;
    logic               r_source;

    logic                          r_start;
    logic [pots_pkg::NOW_W-1:0]    r_now;
    logic signed [VW-1:0]          r_val [pots_pkg::NUM_SOURCES];

    logic signed [11:0]   w_mx_diff;
    logic signed [11:0]   w_my_diff;
    logic signed [VW-1:0] w_mx_val;
    logic signed [VW-1:0] w_my_val;
    logic signed [VW-1:0] n_val [pots_pkg::NUM_SOURCES];

    logic                   w_in_acc;
    logic                   w_trig;
    logic                   w_read;
    logic                   w_busy;
    logic [NUM_PADDLES-1:0] w_running;
    logic [NUM_PADDLES-1:0] w_lane_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap    <= 1'b0;
            r_invert  <= 1'b0;
            r_scale_x <= pots_pkg::SCALE_RESET;
            r_scale_y <= pots_pkg::SCALE_RESET;
            r_trim_x  <= '0;
            r_trim_y  <= '0;
            r_source  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (pots_pkg::t_cfg_idx'(i_cfg_index))
                pots_pkg::CFG_SWAP_AXES:     r_swap    <= i_cfg_data[0];
                pots_pkg::CFG_INVERT_VALUES: r_invert  <= i_cfg_data[0];
                pots_pkg::CFG_SCALE_X:       r_scale_x <= i_cfg_data;
                pots_pkg::CFG_SCALE_Y:       r_scale_y <= i_cfg_data;
                pots_pkg::CFG_TRIM_X:        r_trim_x  <= $signed(i_cfg_data[7:0]);
                pots_pkg::CFG_TRIM_Y:        r_trim_y  <= $signed(i_cfg_data[7:0]);
                pots_pkg::CFG_SOURCE_SELECT: r_source  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_busy     = r_start | (|w_lane_busy);
    assign o_in_ready = !w_busy && (!o_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_trig     = w_in_acc && (i_operation == pots_pkg::OP_TRIGGER);
    assign w_read     = w_in_acc && (i_operation == pots_pkg::OP_READ);

    always_comb begin
        w_mx_diff = $signed({2'b00, i_mouse_x}) - pots_pkg::MOUSE_X_OFS;
        w_my_diff = $signed({2'b00, i_mouse_y}) - pots_pkg::MOUSE_Y_OFS;
        w_mx_val  = VW'(w_mx_diff) * VW'(pots_pkg::MOUSE_X_GAIN);
        w_my_val  = VW'(w_my_diff) * VW'(pots_pkg::MOUSE_Y_GAIN);
        if (r_source) begin
            n_val[0] = w_mx_val;
            n_val[1] = w_my_val;
            n_val[2] = pots_pkg::FIXED_VAL;
            n_val[3] = pots_pkg::FIXED_VAL;
        end else begin
            n_val[0] = VW'(i_value_zero);
            n_val[1] = VW'(i_value_one);
            n_val[2] = VW'(i_value_two);
            n_val[3] = VW'(i_value_three);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= w_trig;
        end
    end

    // sample positions and trigger time
    always_ff @(posedge i_clk) begin
        if (w_trig) begin
            r_now <= i_cycle_time;
            r_val <= n_val;
        end
    end

    for (genvar g = 0; g < NUM_PADDLES; g++) begin : g_lane
        localparam int SRC_STRAIGHT = g;
        localparam int SRC_SWAPPED  = g ^ 1;
        localparam logic ODD        = (g % 2) == 1;

        logic                 w_odd;
        logic signed [VW-1:0] w_value;
        pots_pkg::t_lane_cfg  w_cfg;

        always_comb begin
            w_odd        = r_swap ? !ODD : ODD;
            w_value      = r_swap ? r_val[SRC_SWAPPED] : r_val[SRC_STRAIGHT];
            w_cfg.invert = r_invert;
            w_cfg.scale  = w_odd ? r_scale_y : r_scale_x;
            w_cfg.trim   = w_odd ? r_trim_y : r_trim_x;
        end

        pots_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_start),
            .i_value    (w_value),
            .i_cfg      (w_cfg),
            .i_now      (r_now),
            .i_cmp_time (i_cycle_time),
            .o_running  (w_running[g]),
            .o_busy     (w_lane_busy[g])
        );
    end

    pots_merge #(
        .NUM_PADDLES(NUM_PADDLES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_read),
        .i_take    (i_out_ready),
        .i_index   (i_paddle_index),
        .i_running (w_running),
        .o_valid   (o_out_valid),
        .o_data    (o_read_data)
    );

endmodule

// ===== src/pots_checker.sv =====
// Port-level checks for the paddle one-shot timers, bound to the top level.
// Depends on pots_pkg and paddle_one_shot_timers_top.
module pots_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       o_in_ready,
    input  logic       i_operation,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] o_read_data
);

    // a waiting word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_data)))
        else $error("output word dropped or changed while stalled");

    a_out_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_read_data == pots_pkg::DATA_RUNNING ||
                         o_read_data == pots_pkg::DATA_EXPIRED))
        else $error("read word is neither running nor expired");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == pots_pkg::OP_READ) |=> o_out_valid)
        else $error("accepted read produced no word");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == pots_pkg::OP_TRIGGER) |=>
        (!o_in_ready && !$rose(o_out_valid)))
        else $error("trigger did not hold off input or produced a word");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind paddle_one_shot_timers_top pots_checker u_pots_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_operation (i_operation),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data)
);

// ===== tb/paddle_one_shot_timers_top_tb.sv =====
// Self-checking testbench for paddle_one_shot_timers_top: queued paddle accesses, an
// in-bench deadline predictor and an in-order scoreboard of read words.
// Depends on pots_pkg and the RTL under src.
module paddle_one_shot_timers_top_tb;

    localparam int     TRIGGER_SETTLE = 8;
    localparam int     STALL_LIMIT    = 4000;
    localparam int     PHASE_ITEMS    = 167;
    localparam int     NUM_SETTINGS   = 8;
    localparam int     MISMATCH_SHOWN = 10;
    localparam longint DELAY_NUM      = 1104;
    localparam longint DELAY_DEN      = 100;
    localparam logic [pots_pkg::TIME_BITS_DEF-1:0] DEADLINE_MAX = '1;

    localparam logic [pots_pkg::NOW_W-1:0]     NOW_MAX    = '1;
    localparam logic [pots_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic [16:0] RAW_MIN      = 17'h10000;
    localparam logic [16:0] RAW_MAX      = 17'h0FFFF;
    localparam logic [16:0] RAW_NEG_HALF = 17'h18000;
    localparam logic [16:0] RAW_HALF     = 17'h08000;
    localparam logic [16:0] RAW_NEG_ONE  = 17'h1FFFF;
    localparam logic [16:0] RAW_ZERO     = 17'h00000;

    typedef struct packed {
        logic                       op;
        logic [pots_pkg::NOW_W-1:0] now;
        logic [1:0]                 idx;
        logic [3:0][16:0]           pos;
        logic [9:0]                 mx;
        logic [9:0]                 my;
    } t_paddle_access;

    typedef struct packed {
        logic [7:0]                 data;
        logic [pots_pkg::NOW_W-1:0] now;
        logic [1:0]                 idx;
    } t_read_answer;

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_in_valid     = 1'b0;
    logic                               o_in_ready;
    logic                               i_operation    = pots_pkg::OP_TRIGGER;
    logic [pots_pkg::NOW_W-1:0]         i_cycle_time   = '0;
    logic [1:0]                         i_paddle_index = '0;
    logic signed [16:0]                 i_value_zero   = '0;
    logic signed [16:0]                 i_value_one    = '0;
    logic signed [16:0]                 i_value_two    = '0;
    logic signed [16:0]                 i_value_three  = '0;
    logic [9:0]                         i_mouse_x      = '0;
    logic [9:0]                         i_mouse_y      = '0;
    logic                               o_out_valid;
    logic                               i_out_ready    = 1'b0;
    logic [7:0]                         o_read_data;
    logic                               i_cfg_valid    = 1'b0;
    logic                               o_cfg_ready;
    logic [pots_pkg::CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [pots_pkg::CFG_DATA_W-1:0]    i_cfg_data     = '0;

    // predictor copy of the registers and timers
    logic                    cfg_swap    = 1'b0;
    logic                    cfg_invert  = 1'b0;
    logic [15:0]             cfg_scale_x = pots_pkg::SCALE_RESET;
    logic [15:0]             cfg_scale_y = pots_pkg::SCALE_RESET;
    logic signed [7:0]       cfg_trim_x  = '0;
    logic signed [7:0]       cfg_trim_y  = '0;
    logic                    cfg_mouse   = 1'b0;
    logic [pots_pkg::TIME_BITS_DEF-1:0] deadline [pots_pkg::NUM_PADDLES_DEF];

    t_paddle_access access_q [$];
    t_read_answer   answer_q [$];
    t_paddle_access drive_item;

    int queued_cnt    = 0;
    int accepted_cnt  = 0;
    int triggers_seen = 0;
    int reads_checked = 0;
    int faults        = 0;
    int stuck_cycles  = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;

    paddle_one_shot_timers_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_cycle_time   (i_cycle_time),
        .i_paddle_index (i_paddle_index),
        .i_value_zero   (i_value_zero),
        .i_value_one    (i_value_one),
        .i_value_two    (i_value_two),
        .i_value_three  (i_value_three),
        .i_mouse_x      (i_mouse_x),
        .i_mouse_y      (i_mouse_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sampled_position(t_paddle_access a, int pn);
        if (cfg_mouse) begin
            case (pn)
                0: return (longint'(a.mx) - longint'(pots_pkg::MOUSE_X_OFS)) *
                          longint'(pots_pkg::MOUSE_X_GAIN);
                1: return (longint'(a.my) - longint'(pots_pkg::MOUSE_Y_OFS)) *
                          longint'(pots_pkg::MOUSE_Y_GAIN);
                default: return longint'(pots_pkg::FIXED_VAL);
            endcase
        end
        return longint'($signed(a.pos[pn]));
    endfunction

    // whole cycles from trigger to expiry for one timer, rounded up
    function automatic longint discharge_delay(t_paddle_access a, int lane);
        int     pn;
        longint v;
        longint n;
        pn = cfg_swap ? (lane ^ 1) : lane;
        v  = sampled_position(a, pn);
        if (cfg_invert) v = -v;
        if (pn % 2 == 1) begin
            v = ((v * longint'(cfg_scale_y)) >>> pots_pkg::SCALE_SHIFT) + longint'(cfg_trim_y);
        end else begin
            v = ((v * longint'(cfg_scale_x)) >>> pots_pkg::SCALE_SHIFT) + longint'(cfg_trim_x);
        end
        v = v + longint'(pots_pkg::POS_CENTRE);
        if (v >= longint'(pots_pkg::POS_LIMIT)) v = longint'(pots_pkg::POS_PINNED);
        n = v * DELAY_NUM;
        return (n >= 0) ? (n + DELAY_DEN - 1) / DELAY_DEN : -((-n) / DELAY_DEN);
    endfunction

    task automatic take_access(t_paddle_access a);
        longint       t;
        t_read_answer ans;
        if (a.op == pots_pkg::OP_TRIGGER) begin
            triggers_seen++;
            for (int lane = 0; lane < pots_pkg::NUM_PADDLES_DEF; lane++) begin
                t = longint'(a.now) + discharge_delay(a, lane);
                if (t < 0) deadline[lane] = '0;
                else if (t > longint'(DEADLINE_MAX)) deadline[lane] = DEADLINE_MAX;
                else deadline[lane] = t[pots_pkg::TIME_BITS_DEF-1:0];
            end
        end else begin
            ans.now  = a.now;
            ans.idx  = a.idx;
            ans.data = (a.now < deadline[a.idx % pots_pkg::NUM_PADDLES_DEF])
                       ? pots_pkg::DATA_RUNNING : pots_pkg::DATA_EXPIRED;
            answer_q.push_back(ans);
        end
    endtask

    // sender: hold each word until taken, idle at random between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                take_access(drive_item);
                accepted_cnt++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (access_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drive_item = access_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_operation    <= drive_item.op;
                    i_cycle_time   <= drive_item.now;
                    i_paddle_index <= drive_item.idx;
                    i_value_zero   <= drive_item.pos[0];
                    i_value_one    <= drive_item.pos[1];
                    i_value_two    <= drive_item.pos[2];
                    i_value_three  <= drive_item.pos[3];
                    i_mouse_x      <= drive_item.mx;
                    i_mouse_y      <= drive_item.my;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each read word against the oldest answer, stall at random
    always @(posedge i_clk) begin
        t_read_answer ans;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                reads_checked++;
                if (answer_q.size() == 0) begin
                    if (faults < MISMATCH_SHOWN)
                        $display("read word %h arrived with no read pending", o_read_data);
                    faults++;
                end else begin
                    ans = answer_q.pop_front();
                    if (o_read_data !== ans.data) begin
                        if (faults < MISMATCH_SHOWN)
                            $display("read of paddle %0d at cycle %0d: expected %h, got %h",
                                     ans.idx, ans.now, ans.data, o_read_data);
                        faults++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("no word moved for %0d cycles, %0d reads outstanding",
                         STALL_LIMIT, answer_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_paddle_access make_access(logic op, logic [pots_pkg::NOW_W-1:0] now,
                                                   logic [1:0] idx, logic [16:0] v0,
                                                   logic [16:0] v1, logic [16:0] v2,
                                                   logic [16:0] v3, logic [9:0] mx,
                                                   logic [9:0] my);
        t_paddle_access a;
        a.op     = op;
        a.now    = now;
        a.idx    = idx;
        a.pos[0] = v0;
        a.pos[1] = v1;
        a.pos[2] = v2;
        a.pos[3] = v3;
        a.mx     = mx;
        a.my     = my;
        return a;
    endfunction

    function automatic logic [16:0] rand_position();
        logic [16:0] r;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 5))
                    0: r = RAW_MIN;
                    1: r = RAW_MAX;
                    2: r = RAW_NEG_HALF;
                    3: r = RAW_HALF;
                    4: r = RAW_NEG_ONE;
                    default: r = RAW_ZERO;
                endcase
            end
            1: r = 17'($urandom);
            default: r = 17'($urandom_range(0, 65536) - 32768);
        endcase
        return r;
    endfunction

    function automatic logic [9:0] rand_mouse(logic vertical);
        logic [9:0] r;
        if ($urandom_range(0, 2) == 0) r = 10'($urandom);
        else r = 10'($urandom_range(0, vertical ? 384 : 560));
        return r;
    endfunction

    function automatic logic [pots_pkg::NOW_W-1:0] rand_now();
        logic [63:0] r;
        case ($urandom_range(0, 7))
            0: r = 64'($urandom_range(0, 2000));
            1: r = 64'(NOW_MAX - pots_pkg::NOW_W'($urandom_range(0, 4000)));
            default: r = {$urandom, $urandom};
        endcase
        return r[pots_pkg::NOW_W-1:0];
    endfunction

    task automatic queue_access(t_paddle_access a);
        access_q.push_back(a);
        queued_cnt++;
    endtask

    // a trigger followed by reads, most aimed near the deadlines it sets, or a stray access
    task automatic queue_burst();
        t_paddle_access             trig;
        logic [pots_pkg::NOW_W-1:0] base;
        longint                     t;
        int                         lane;
        int                         jitter;
        if ($urandom_range(0, 99) < 15) begin
            queue_access(make_access(1'($urandom_range(0, 1)), rand_now(),
                                     2'($urandom_range(0, 3)),
                                     rand_position(), rand_position(), rand_position(),
                                     rand_position(), rand_mouse(1'b0), rand_mouse(1'b1)));
        end else begin
            base = rand_now();
            trig = make_access(pots_pkg::OP_TRIGGER, base, 2'($urandom_range(0, 3)),
                               rand_position(), rand_position(), rand_position(),
                               rand_position(), rand_mouse(1'b0), rand_mouse(1'b1));
            queue_access(trig);
            repeat ($urandom_range(1, 6)) begin
                lane = int'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        jitter = int'($urandom_range(0, 2));
                        t = longint'(base) + discharge_delay(trig, lane) + jitter - 1;
                    end
                    4, 5, 6: t = longint'(base) + longint'($urandom_range(0, 3200));
                    7, 8: begin
                        jitter = int'($urandom_range(0, 80));
                        t = longint'(base) + discharge_delay(trig, lane) + jitter - 40;
                    end
                    default: t = longint'(rand_now());
                endcase
                queue_access(make_access(pots_pkg::OP_READ, t[pots_pkg::NOW_W-1:0], 2'(lane),
                                         rand_position(), rand_position(), rand_position(),
                                         rand_position(), rand_mouse(1'b0), rand_mouse(1'b1)));
            end
        end
    endtask

    task automatic write_reg(logic [pots_pkg::CFG_IDX_W-1:0] idx,
                             logic [pots_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pots_pkg::CFG_SWAP_AXES:     cfg_swap    = data[0];
            pots_pkg::CFG_INVERT_VALUES: cfg_invert  = data[0];
            pots_pkg::CFG_SCALE_X:       cfg_scale_x = data;
            pots_pkg::CFG_SCALE_Y:       cfg_scale_y = data;
            pots_pkg::CFG_TRIM_X:        cfg_trim_x  = data[7:0];
            pots_pkg::CFG_TRIM_Y:        cfg_trim_y  = data[7:0];
            pots_pkg::CFG_SOURCE_SELECT: cfg_mouse   = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return pots_pkg::SCALE_RESET;
            default: return 16'($urandom_range(0, 1024));
        endcase
    endfunction

    task automatic apply_setting(int phase);
        logic        swap;
        logic        inv;
        logic        mouse;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [15:0] junk;
        case (phase)
            0: {swap, inv, sx, sy, tx, ty, mouse} =
                   {1'b0, 1'b0, pots_pkg::SCALE_RESET, pots_pkg::SCALE_RESET, 8'h00, 8'h00,
                    1'b0};
            1: {swap, inv, sx, sy, tx, ty, mouse} =
                   {1'b1, 1'b1, 16'hFFFF, 16'h0000, 8'h80, 8'h7F, 1'b0};
            2: {swap, inv, sx, sy, tx, ty, mouse} =
                   {1'b0, 1'b0, 16'h0000, 16'hFFFF, 8'h7F, 8'h80, 1'b1};
            3: {swap, inv, sx, sy, tx, ty, mouse} =
                   {1'b1, 1'b0, pots_pkg::SCALE_RESET, pots_pkg::SCALE_RESET, 8'h00, 8'h00,
                    1'b1};
            default: begin
                swap  = 1'($urandom_range(0, 1));
                inv   = 1'($urandom_range(0, 1));
                mouse = 1'($urandom_range(0, 1));
                sx    = rand_scale();
                sy    = rand_scale();
                tx    = 8'($urandom);
                ty    = 8'($urandom);
            end
        endcase
        // fill unused data bits with noise, the block must drop them
        junk = 16'($urandom);
        write_reg(pots_pkg::CFG_SWAP_AXES, {junk[15:1], swap});
        junk = 16'($urandom);
        write_reg(pots_pkg::CFG_INVERT_VALUES, {junk[15:1], inv});
        write_reg(pots_pkg::CFG_SCALE_X, sx);
        write_reg(pots_pkg::CFG_SCALE_Y, sy);
        junk = 16'($urandom);
        write_reg(pots_pkg::CFG_TRIM_X, {junk[15:8], tx});
        junk = 16'($urandom);
        write_reg(pots_pkg::CFG_TRIM_Y, {junk[15:8], ty});
        junk = 16'($urandom);
        write_reg(pots_pkg::CFG_SOURCE_SELECT, {junk[15:1], mouse});
        if (phase == 0 || $urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    // hold until every word is taken and answered, then let a trigger settle
    task automatic drain();
        while (accepted_cnt != queued_cnt || answer_q.size() != 0) @(posedge i_clk);
        repeat (TRIGGER_SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int target;
        for (int lane = 0; lane < pots_pkg::NUM_PADDLES_DEF; lane++) deadline[lane] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads before any trigger, then the pinned, centre and negative cases
        queue_access(make_access(pots_pkg::OP_READ, '0, 2'd0, RAW_ZERO, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, NOW_MAX, 2'd3, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_TRIGGER, '0, 2'd0, RAW_MIN, RAW_HALF, RAW_ZERO,
                                 RAW_MAX, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd0, 2'd0, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd3091, 2'd1, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd3092, 2'd1, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd1413, 2'd2, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd1414, 2'd2, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd3091, 2'd3, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd3092, 2'd3, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_TRIGGER, NOW_MAX, 2'd3, RAW_NEG_ONE,
                                 RAW_NEG_HALF, RAW_MAX, 17'h00001, 10'h3FF, 10'h3FF));
        queue_access(make_access(pots_pkg::OP_READ, NOW_MAX, 2'd0, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, NOW_MAX, 2'd1, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd0, 2'd2, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, NOW_MAX, 2'd3, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_TRIGGER, 47'd100, 2'd1, RAW_MIN, RAW_MIN,
                                 17'h10001, RAW_NEG_HALF, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd0, 2'd0, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd99, 2'd3, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        queue_access(make_access(pots_pkg::OP_READ, 47'd100, 2'd3, RAW_ZERO, RAW_ZERO,
                                 RAW_ZERO, RAW_ZERO, 10'd0, 10'd0));
        drain();

        for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
            apply_setting(phase);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            target = queued_cnt + PHASE_ITEMS;
            while (queued_cnt < target) queue_burst();
            drain();
        end

        if (answer_q.size() != 0) begin
            $display("%0d read words never arrived", answer_q.size());
            faults += answer_q.size();
        end
        $display("Covered %0d accesses: %0d triggers, %0d read words over %0d settings,",
                 accepted_cnt, triggers_seen, reads_checked, NUM_SETTINGS + 1);
        $display("paced with sender gaps and receiver stalls of 0, 37 and 68 percent; %0d faults",
                 faults);
        if (faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
